### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/sha1e_pkg.sv
// ----------------------------------------------------------------------------
// sha1e_pkg
// Types, constants and helpers shared by the SHA-1 engine modules.
// ----------------------------------------------------------------------------
package sha1e_pkg;

  localparam int unsigned NUM_H = 5;

  localparam logic [6:0] LAST_ROUND   = 7'd79;
  localparam logic [6:0] EXPAND_START = 7'd16;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_POS     = 6'd63;
  localparam logic [1:0] LANE_LAST    = 2'd3;
  localparam logic [2:0] LAST_WORD    = 3'd4;
  localparam logic [7:0] PAD_BYTE     = 8'h80;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PB  = 32'hCA62C1D6;

  // Five 32-bit words: chaining values or working variables a..e (index 0 = a)
  typedef logic [NUM_H-1:0][31:0] hvec_t;

  typedef enum logic [1:0] {
    PH_CH  = 2'd0,
    PH_PA  = 2'd1,
    PH_MAJ = 2'd2,
    PH_PB  = 2'd3
  } rphase_t;

  typedef struct packed {
    logic       load_en;
    logic [7:0] data;
    logic [1:0] lane;
    logic       shift_en;
    logic       expand;
  } sched_ctrl_t;

  function automatic hvec_t h_init();
    hvec_t h;
    h[0] = 32'h67452301;
    h[1] = 32'hEFCDAB89;
    h[2] = 32'h98BADCFE;
    h[3] = 32'h10325476;
    h[4] = 32'hC3D2E1F0;
    return h;
  endfunction

endpackage

### rtl/sha1e_round.sv
// ----------------------------------------------------------------------------
// sha1e_round
// One SHA-1 round: logic function, constant and the five-operand add.
// ----------------------------------------------------------------------------
module sha1e_round (
  input  sha1e_pkg::hvec_t   vars_in,
  input  logic [31:0]        w_cur,
  input  sha1e_pkg::rphase_t phase,
  output sha1e_pkg::hvec_t   vars_out
);
  import sha1e_pkg::*;

  logic [31:0] b, c, d;
  logic [31:0] f, k, t;

  assign b = vars_in[1];
  assign c = vars_in[2];
  assign d = vars_in[3];

  always_comb begin
    case (phase)
      PH_CH: begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end
      PH_PA: begin
        f = b ^ c ^ d;
        k = K_PA;
      end
      PH_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end
      PH_PB: begin
        f = b ^ c ^ d;
        k = K_PB;
      end
      default: begin
        f = b ^ c ^ d;
        k = K_PB;
      end
    endcase
  end

  assign t = {vars_in[0][26:0], vars_in[0][31:27]} + f + vars_in[4] + k + w_cur;

  assign vars_out[0] = t;
  assign vars_out[1] = vars_in[0];
  assign vars_out[2] = {b[1:0], b[31:2]};
  assign vars_out[3] = c;
  assign vars_out[4] = d;

endmodule

### rtl/sha1e_sched.sv
// ----------------------------------------------------------------------------
// sha1e_sched
// Message block as a 16-word shift line: packs bytes into words on absorb and
// produces the expanded schedule word during the rounds.
// ----------------------------------------------------------------------------
module sha1e_sched (
  input  logic                   clk,
  input  sha1e_pkg::sched_ctrl_t ctrl,
  output logic [31:0]            w_cur
);
  import sha1e_pkg::*;

  logic [23:0] acc_r;
  logic [31:0] line_r   [16];
  logic [31:0] line_nxt [16];
  logic [31:0] mix;
  logic        push;
  logic [31:0] push_word;

  // line_r[k] holds W(t-16+k) during the expanded rounds
  assign mix   = line_r[13] ^ line_r[8] ^ line_r[2] ^ line_r[0];
  assign w_cur = ctrl.expand ? {mix[30:0], mix[31]} : line_r[0];

  assign push      = ctrl.shift_en || (ctrl.load_en && (ctrl.lane == LANE_LAST));
  assign push_word = ctrl.shift_en ? w_cur : {acc_r, ctrl.data};

  always_comb begin
    for (int i = 0; i < 16; i++) line_nxt[i] = line_r[i];
    if (push) begin
      for (int i = 0; i < 15; i++) line_nxt[i] = line_r[i + 1];
      line_nxt[15] = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_en) acc_r <= {acc_r[15:0], ctrl.data};
    for (int i = 0; i < 16; i++) line_r[i] <= line_nxt[i];
  end

endmodule

### rtl/sha1_hash_engine_core.sv
// Blocks: a byte that fills a block starts 80 rounds on the shared round unit, then
//   one chaining add; other bytes are just stored.
// End item: the padding bytes (9 to 72) are loaded and each padding block is hashed,
//   then the five digest words, one per cycle when the output side does not stall.
// Input: in_stall is high whenever the engine is not idle.
// Reset: synchronous, active low; loads the initial chaining words, clears counts and control.
// ----------------------------------------------------------------------------
// sha1_hash_engine_core
// Byte-serial SHA-1 engine with one round per cycle under a small sequencer.
// ----------------------------------------------------------------------------
module sha1_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_word_last
);
  import sha1e_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  hvec_t       h_r, h_nxt;
  hvec_t       v_r, v_nxt, v_round;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [60:0] count_r, count_nxt;
  logic        fin_r, fin_nxt;
  logic        last_blk_r, last_blk_nxt;
  logic        sent80_r, sent80_nxt;
  logic        need_wrap_r, need_wrap_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  sched_ctrl_t sc;
  logic [31:0] w_cur;
  rphase_t     phase;
  logic [63:0] len_sh;
  logic        is_len;
  logic [7:0]  pad_byte;

  sha1e_sched u_sched (
    .clk   (clk),
    .ctrl  (sc),
    .w_cur (w_cur)
  );

  sha1e_round u_round (
    .vars_in  (v_r),
    .w_cur    (w_cur),
    .phase    (phase),
    .vars_out (v_round)
  );

  always_comb begin
    if (rnd_r inside {[7'd0:7'd19]})       phase = PH_CH;
    else if (rnd_r inside {[7'd20:7'd39]}) phase = PH_PA;
    else if (rnd_r inside {[7'd40:7'd59]}) phase = PH_MAJ;
    else                                   phase = PH_PB;
  end

  // Length bytes, most significant first, at block positions 56..63
  assign len_sh = {count_r, 3'b000} >> {3'd7 - pos_r[2:0], 3'b000};
  assign is_len = sent80_r && (pos_r >= LEN_POS) && !need_wrap_r;

  always_comb begin
    if (!sent80_r)   pad_byte = PAD_BYTE;
    else if (is_len) pad_byte = len_sh[7:0];
    else             pad_byte = 8'h00;
  end

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    rnd_nxt       = rnd_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    fin_nxt       = fin_r;
    last_blk_nxt  = last_blk_r;
    sent80_nxt    = sent80_r;
    need_wrap_nxt = need_wrap_r;
    oidx_nxt      = oidx_r;
    sc            = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fin_nxt       = in_end_of_message;
          sent80_nxt    = 1'b0;
          need_wrap_nxt = 1'b0;
          last_blk_nxt  = 1'b0;
          if (in_has_byte) begin
            sc.load_en = 1'b1;
            sc.data    = in_data_byte;
            sc.lane    = pos_r[1:0];
            pos_nxt    = pos_r + 6'd1;
            count_nxt  = count_r + 61'd1;
            if (pos_r == LAST_POS) begin
              state_nxt = ST_ROUND;
              v_nxt     = h_r;
              rnd_nxt   = '0;
            end else if (in_end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        sc.load_en = 1'b1;
        sc.data    = pad_byte;
        sc.lane    = pos_r[1:0];
        pos_nxt    = pos_r + 6'd1;
        if (!sent80_r) begin
          sent80_nxt    = 1'b1;
          // no room for the length: zero-fill this block and go one more
          need_wrap_nxt = (pos_r >= LEN_POS);
        end
        if (pos_r == LAST_POS) begin
          state_nxt     = ST_ROUND;
          v_nxt         = h_r;
          rnd_nxt       = '0;
          last_blk_nxt  = is_len;
          need_wrap_nxt = 1'b0;
        end
      end

      ST_ROUND: begin
        sc.shift_en = 1'b1;
        sc.expand   = (rnd_r >= EXPAND_START);
        v_nxt       = v_round;
        rnd_nxt     = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) state_nxt = ST_FINAL;
      end

      ST_FINAL: begin
        for (int i = 0; i < NUM_H; i++) h_nxt[i] = h_r[i] + v_r[i];
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (last_blk_r) begin
          state_nxt = ST_OUT;
          oidx_nxt  = '0;
        end else begin
          state_nxt = ST_PAD;
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          if (oidx_r == LAST_WORD) begin
            state_nxt = ST_IDLE;
            h_nxt     = h_init();
            count_nxt = '0;
            pos_nxt   = '0;
            fin_nxt   = 1'b0;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= h_init();
      rnd_r       <= '0;
      pos_r       <= '0;
      count_r     <= '0;
      fin_r       <= 1'b0;
      last_blk_r  <= 1'b0;
      sent80_r    <= 1'b0;
      need_wrap_r <= 1'b0;
      oidx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      rnd_r       <= rnd_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      fin_r       <= fin_nxt;
      last_blk_r  <= last_blk_nxt;
      sent80_r    <= sent80_nxt;
      need_wrap_r <= need_wrap_nxt;
      oidx_r      <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  always_comb begin
    case (oidx_r)
      3'd0:    out_digest_word = h_r[0];
      3'd1:    out_digest_word = h_r[1];
      3'd2:    out_digest_word = h_r[2];
      3'd3:    out_digest_word = h_r[3];
      3'd4:    out_digest_word = h_r[4];
      default: out_digest_word = h_r[0];
    endcase
  end

  assign out_valid     = (state_r == ST_OUT);
  assign out_word_last = (oidx_r == LAST_WORD);
  assign in_stall      = (state_r != ST_IDLE);

endmodule

### rtl/sha1e_checker.sv
// ----------------------------------------------------------------------------
// sha1e_checker
// Port-level checks on the SHA-1 engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1e_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic        out_word_last
);

  logic in_acc, out_acc, out_wait;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_wait = out_valid && out_stall;

  // no item taken while the digest is being delivered
  `CHK_SAME(a_busy_out, clk, rst_n, out_valid, in_stall)

  // stalled digest word holds
  `CHK_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_digest_word))
  `CHK_NEXT(a_last_hold, clk, rst_n, out_wait, $stable(out_word_last))

  // digest ends after the last word
  `CHK_NEXT(a_last_done, clk, rst_n, out_acc && out_word_last, !out_valid)

  // only an end-marked item leads to results
  `CHK_NEXT(a_no_early, clk, rst_n, in_acc && !in_end_of_message, !out_valid)

endmodule

bind sha1_hash_engine_core sha1e_checker u_sha1e_checker (.*);

### sim/sha1_hash_engine_core_tb.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_core_tb
// Sends byte-serial messages to the SHA-1 engine: a few hand-picked cases, then
// random messages whose lengths cluster around the padding and block boundaries,
// with noise items mixed in. A scoreboard class recomputes each digest and checks
// the five output words in order. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module sha1_hash_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1e_pkg::*;

  localparam hvec_t H_START = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  class digest_scoreboard;
    hvec_t        chain_h;
    logic [31:0]  msg_words [16];
    logic [60:0]  byte_total;
    digest_word_t digest_q [$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain_h = H_START;
      foreach (msg_words[i]) msg_words[i] = '0;
      byte_total = '0;
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    function void place_byte(int pos, logic [7:0] v);
      int          idx;
      int          lane;
      logic [31:0] shifted;
      idx = (pos >> 2) & 15;
      lane = pos & 3;
      shifted = {24'h0, v} << ((3 - lane) * 8);
      // a byte in the top lane starts a fresh word
      if (lane == 0) begin
        msg_words[idx] = shifted;
      end else begin
        msg_words[idx] = msg_words[idx] | shifted;
      end
    endfunction

    function void compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) sched[r] = msg_words[r];
      for (int r = 16; r < 80; r++) begin
        t = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
        sched[r] = {t[30:0], t[31]};
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_CH;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_PA;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_MAJ;
        end else begin
          f = b ^ c ^ d;
          k = K_PB;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[r];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain_h[0] = chain_h[0] + a;
      chain_h[1] = chain_h[1] + b;
      chain_h[2] = chain_h[2] + c;
      chain_h[3] = chain_h[3] + d;
      chain_h[4] = chain_h[4] + e;
    endfunction

    function void absorb_item(logic [7:0] data, logic has, logic eom);
      int          pos;
      logic [63:0] bit_len;
      digest_word_t dw;
      if (has) begin
        pos = int'(byte_total[5:0]);
        place_byte(pos, data);
        byte_total = byte_total + 61'd1;
        if (pos == 63) compress_block();
      end
      if (!eom) return;
      pos = int'(byte_total[5:0]);
      place_byte(pos, PAD_BYTE);
      for (int i = (pos >> 2) + 1; i < 16; i++) msg_words[i] = '0;
      // no room for the length: spill into an extra block
      if (pos >= 56) begin
        compress_block();
        foreach (msg_words[i]) msg_words[i] = '0;
      end
      bit_len = {byte_total, 3'b000};
      msg_words[14] = bit_len[63:32];
      msg_words[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) begin
        dw.word = chain_h[i];
        dw.last = (i == 4);
        digest_q.push_back(dw);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic last);
      digest_word_t want;
      if (digest_q.size() == 0) begin
        $display("%0t: digest word with none pending: expected none, actual %h last %b",
                 $time, word, last);
        errors++;
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word) begin
        $display("%0t: digest_word mismatch: expected %h, actual %h",
                 $time, want.word, word);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: word_last mismatch: expected %b, actual %b",
                 $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic        out_word_last;

  digest_scoreboard sb = new();
  bit send_gaps;
  bit stall_gaps;
  int byte_items;
  int msg_count;

  sha1_hash_engine_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_last     (out_word_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.absorb_item(in_data_byte, in_has_byte, in_end_of_message);
      if (out_valid && !out_stall) sb.check_word(out_digest_word, out_word_last);
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (stall_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_has_byte       <= has;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    bit eom_alone;
    eom_alone = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      // drop in an idle item now and then
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, !eom_alone && (i == len - 1));
      byte_items++;
    end
    if (eom_alone) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      byte_items++;
    end
    msg_count++;
  endtask

  // step past the accepting edge first so the last item is already noted
  task automatic wait_for_digests();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 8);
    else if (r < 9) return $urandom_range(54, 66);
    else return $urandom_range(118, 130);
  endfunction

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_data_byte      <= 8'h00;
    in_has_byte       <= 1'b0;
    in_end_of_message <= 1'b0;
    send_gaps  = 1'b1;
    stall_gaps = 1'b1;
    byte_items = 0;
    msg_count  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message straight out of reset, an idle item, then two one-byte messages
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // "abc" closed by an end mark with no byte, then another empty message
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b1);

    // hold off until every digest is out
    in_valid <= 1'b0;
    wait_for_digests();

    while (byte_items < 110 || msg_count < 4) begin
      send_gaps  = ($urandom_range(0, 3) != 0);
      stall_gaps = ($urandom_range(0, 3) != 0);
      send_message(pick_length());
    end

    // quiet tail: no gaps on either side
    send_gaps  = 1'b0;
    stall_gaps = 1'b0;
    repeat (3) send_message($urandom_range(0, 12));
    in_valid <= 1'b0;

    wait_for_digests();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sha1_hash_engine_core.f
+incdir+rtl
rtl/sha1e_pkg.sv
rtl/sha1e_round.sv
rtl/sha1e_sched.sv
rtl/sha1_hash_engine_core.sv
rtl/sha1e_checker.sv
sim/sha1_hash_engine_core_tb.sv
